[rtl/frba_pkg.sv]
// Package for the helicity-frame projection block: fixed-point constants,
// the shared accumulator type and the Q2.30 rounding function.
// Depends on nothing.
package frba_pkg;

    // Fraction bits of the unit axis components (Q2.30).
    localparam int FRAC_BITS = 30;
    // Left shift of the squared length before the square root (length in Q.8).
    localparam int SQ_SHIFT = 16;
    // Left shift of the component magnitude in the unit division.
    localparam int DIV_SHIFT = 39;
    // Quotient bits of a unit component magnitude.
    localparam int QUOT_BITS = 31;
    // Width of the signed accumulator used for rounding.
    localparam int ACC_WIDTH = 72;

    typedef logic signed [ACC_WIDTH-1:0] acc_t;

    // Round a Q.30 value to an integer, to nearest with ties away from zero.
    function automatic acc_t round_q30(input acc_t v);
        acc_t m;
        m = v[ACC_WIDTH-1] ? -v : v;
        m = (m + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return v[ACC_WIDTH-1] ? -m : m;
    endfunction

endpackage

[rtl/frame_rotation_to_beam_axes_top.sv]
// Stages in order: capture, squares, lengths, square root (one result bit per stage),
// unit divisions (31 stages), signs, cross product, rounding, products, sums, output.
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while a finished result waits. aresetn (synchronous, active low) clears the
// valid bits only; data registers are not reset.
// Uses frba_pkg for constants and rounding.
module frame_rotation_to_beam_axes_top #(
    parameter int COMP_WIDTH = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COMP_WIDTH-1:0] s_inc_x,
    input  logic signed [COMP_WIDTH-1:0] s_inc_y,
    input  logic signed [COMP_WIDTH-1:0] s_inc_z,
    input  logic signed [COMP_WIDTH-1:0] s_sc_x,
    input  logic signed [COMP_WIDTH-1:0] s_sc_y,
    input  logic signed [COMP_WIDTH-1:0] s_sc_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COMP_WIDTH:0]   m_rot_x,
    output logic signed [COMP_WIDTH:0]   m_rot_y,
    output logic signed [COMP_WIDTH:0]   m_rot_z
);

    localparam int W   = COMP_WIDTH;
    localparam int RW  = W + frba_pkg::SQ_SHIFT / 2;
    localparam int XW  = 2 * W + frba_pkg::SQ_SHIFT;
    localparam int NW  = W + frba_pkg::DIV_SHIFT;
    localparam int QB  = frba_pkg::QUOT_BITS;
    localparam int UW  = QB + 1;
    localparam int XPW = UW + 1;
    localparam int PW  = W + XPW;
    localparam int SW  = PW + 2;
    localparam int OW  = W + 1;
    localparam int IU  = 3 + RW + QB;
    localparam int NST = IU + 6;

    localparam frba_pkg::acc_t OUT_MAX = (frba_pkg::acc_t'(1) <<< W) - frba_pkg::acc_t'(1);
    localparam frba_pkg::acc_t OUT_MIN = -(frba_pkg::acc_t'(1) <<< W);
    localparam logic signed [UW-1:0] UNIT_ONE = {2'b01, {frba_pkg::FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic signed [W-1:0] ux;
        logic signed [W-1:0] uy;
        logic signed [W-1:0] uz;
        logic signed [W-1:0] vx;
        logic signed [W-1:0] vy;
        logic signed [W-1:0] vz;
    } carry_t;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [RW:0]   rem;
        logic [RW-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QB-1:0] q;
    } div_t;

    // Magnitude of a signed component as an unsigned value of the same width.
    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        return a[W-1] ? W'(-a) : W'(a);
    endfunction

    function automatic sqrt_t sqrt_init(input logic [2*W-1:0] s);
        sqrt_t st;
        st.x    = {s, {frba_pkg::SQ_SHIFT{1'b0}}};
        st.rem  = '0;
        st.root = '0;
        return st;
    endfunction

    // One digit of the square root: bring down two bits and try a 1.
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        sqrt_t            n;
        logic [RW+2:0]    cur;
        logic [RW+2:0]    trial;
        cur   = {s.rem, s.x[XW-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        n.x   = s.x << 2;
        if (cur >= trial) begin
            n.rem  = (RW+1)'(cur - trial);
            n.root = {s.root[RW-2:0], 1'b1};
        end else begin
            n.rem  = (RW+1)'(cur);
            n.root = {s.root[RW-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic div_t div_init(input logic [W-1:0] m, input logic [RW-1:0] len);
        div_t d;
        d.rem = (NW'(m) << frba_pkg::DIV_SHIFT) + NW'(len);
        d.q   = '0;
        return d;
    endfunction

    // One quotient bit of the restoring division at bit position p.
    function automatic div_t div_step(input div_t d, input logic [RW:0] dvs, input int p);
        div_t          n;
        logic [NW-1:0] dsh;
        dsh = NW'(dvs) << p;
        n   = d;
        if (d.rem >= dsh) begin
            n.rem = d.rem - dsh;
            n.q   = d.q | (QB'(1) << p);
        end
        return n;
    endfunction

    // Clamp a rounded projection into the signed output range.
    function automatic logic signed [OW-1:0] sat_out(input frba_pkg::acc_t v);
        if (v > OUT_MAX) begin
            return OW'(OUT_MAX);
        end else if (v < OUT_MIN) begin
            return OW'(OUT_MIN);
        end
        return OW'(v);
    endfunction

    logic [NST-1:0] vld_reg;
    logic           adv;

    carry_t          c1_reg, c2_reg, c3_reg;
    logic [2*W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [2*W-1:0]  s2z_reg, t2_reg;

    sqrt_t  rz_reg  [RW];
    sqrt_t  ry_reg  [RW];
    sqrt_t  rz_next [RW];
    sqrt_t  ry_next [RW];
    carry_t cs_reg  [RW];

    div_t          dv_reg  [QB][5];
    div_t          dv_next [QB][5];
    logic [RW-1:0] lz_dv_reg [QB];
    logic [RW-1:0] ly_dv_reg [QB];
    carry_t        cd_reg    [QB];

    logic signed [UW-1:0]   zp_reg [3];
    logic signed [UW-1:0]   yp_reg [2];
    carry_t                 cu_reg;
    logic signed [2*UW-1:0] pcr_reg [4];
    logic signed [UW-1:0]   zp_m_reg [3];
    logic signed [UW-1:0]   yp_m_reg [2];
    carry_t                 cm_reg;
    logic signed [XPW-1:0]  xp_reg [3];
    logic signed [UW-1:0]   zp_r_reg [3];
    logic signed [UW-1:0]   yp_r_reg [2];
    carry_t                 cr_reg;
    logic signed [PW-1:0]   pp_reg [8];
    logic signed [SW-1:0]   acc_reg [3];
    logic signed [OW-1:0]   rot_x_reg, rot_y_reg, rot_z_reg;

    // The pipeline moves whenever the output stage is empty or being taken.
    assign adv     = !vld_reg[NST-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NST-1];
    assign m_rot_x = rot_x_reg;
    assign m_rot_y = rot_y_reg;
    assign m_rot_z = rot_z_reg;

    // Valid bits travel with the data through every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // Square root stages for the full length and the transverse length.
    always_comb begin
        rz_next[0] = sqrt_step(sqrt_init(s2z_reg));
        ry_next[0] = sqrt_step(sqrt_init(t2_reg));
        for (int k = 1; k < RW; k++) begin
            rz_next[k] = sqrt_step(rz_reg[k-1]);
            ry_next[k] = sqrt_step(ry_reg[k-1]);
        end
    end

    // Division stages: three lanes over the full length, two over the transverse one.
    always_comb begin
        dv_next[0][0] = div_step(div_init(mag(cs_reg[RW-1].ux), rz_reg[RW-1].root),
                                 {rz_reg[RW-1].root, 1'b0}, QB - 1);
        dv_next[0][1] = div_step(div_init(mag(cs_reg[RW-1].uy), rz_reg[RW-1].root),
                                 {rz_reg[RW-1].root, 1'b0}, QB - 1);
        dv_next[0][2] = div_step(div_init(mag(cs_reg[RW-1].uz), rz_reg[RW-1].root),
                                 {rz_reg[RW-1].root, 1'b0}, QB - 1);
        dv_next[0][3] = div_step(div_init(mag(cs_reg[RW-1].uy), ry_reg[RW-1].root),
                                 {ry_reg[RW-1].root, 1'b0}, QB - 1);
        dv_next[0][4] = div_step(div_init(mag(cs_reg[RW-1].ux), ry_reg[RW-1].root),
                                 {ry_reg[RW-1].root, 1'b0}, QB - 1);
        for (int k = 1; k < QB; k++) begin
            for (int j = 0; j < 3; j++) begin
                dv_next[k][j] = div_step(dv_reg[k-1][j], {lz_dv_reg[k-1], 1'b0},
                                         QB - 1 - k);
            end
            for (int j = 3; j < 5; j++) begin
                dv_next[k][j] = div_step(dv_reg[k-1][j], {ly_dv_reg[k-1], 1'b0},
                                         QB - 1 - k);
            end
        end
    end

    // Data path registers; they load on every pipeline advance.
    always_ff @(posedge aclk) begin
        if (adv) begin
            // Input capture.
            c1_reg <= '{ux: s_inc_x, uy: s_inc_y, uz: s_inc_z,
                        vx: s_sc_x, vy: s_sc_y, vz: s_sc_z};

            // Squares of the incident components.
            c2_reg  <= c1_reg;
            sqx_reg <= (2*W)'(mag(c1_reg.ux)) * (2*W)'(mag(c1_reg.ux));
            sqy_reg <= (2*W)'(mag(c1_reg.uy)) * (2*W)'(mag(c1_reg.uy));
            sqz_reg <= (2*W)'(mag(c1_reg.uz)) * (2*W)'(mag(c1_reg.uz));

            // Squared transverse and full lengths.
            c3_reg  <= c2_reg;
            t2_reg  <= sqx_reg + sqy_reg;
            s2z_reg <= sqx_reg + sqy_reg + sqz_reg;

            for (int k = 0; k < RW; k++) begin
                rz_reg[k] <= rz_next[k];
                ry_reg[k] <= ry_next[k];
            end
            cs_reg[0] <= c3_reg;
            for (int k = 1; k < RW; k++) begin
                cs_reg[k] <= cs_reg[k-1];
            end

            for (int k = 0; k < QB; k++) begin
                for (int j = 0; j < 5; j++) begin
                    dv_reg[k][j] <= dv_next[k][j];
                end
            end
            lz_dv_reg[0] <= rz_reg[RW-1].root;
            ly_dv_reg[0] <= ry_reg[RW-1].root;
            cd_reg[0]    <= cs_reg[RW-1];
            for (int k = 1; k < QB; k++) begin
                lz_dv_reg[k] <= lz_dv_reg[k-1];
                ly_dv_reg[k] <= ly_dv_reg[k-1];
                cd_reg[k]    <= cd_reg[k-1];
            end

            // Signed unit components; a zero length gives a zero axis.
            cu_reg <= cd_reg[QB-1];
            if (lz_dv_reg[QB-1] == '0) begin
                zp_reg[0] <= '0;
                zp_reg[1] <= '0;
                zp_reg[2] <= '0;
            end else begin
                zp_reg[0] <= cd_reg[QB-1].ux[W-1] ? -signed'({1'b0, dv_reg[QB-1][0].q})
                                                  : signed'({1'b0, dv_reg[QB-1][0].q});
                zp_reg[1] <= cd_reg[QB-1].uy[W-1] ? -signed'({1'b0, dv_reg[QB-1][1].q})
                                                  : signed'({1'b0, dv_reg[QB-1][1].q});
                zp_reg[2] <= cd_reg[QB-1].uz[W-1] ? -signed'({1'b0, dv_reg[QB-1][2].q})
                                                  : signed'({1'b0, dv_reg[QB-1][2].q});
            end
            if (ly_dv_reg[QB-1] == '0) begin
                yp_reg[0] <= '0;
                yp_reg[1] <= '0;
            end else begin
                yp_reg[0] <= cd_reg[QB-1].uy[W-1] ? -signed'({1'b0, dv_reg[QB-1][3].q})
                                                  : signed'({1'b0, dv_reg[QB-1][3].q});
                // The second transverse component follows the sign of minus u_x.
                yp_reg[1] <= (cd_reg[QB-1].ux > 0) ? -signed'({1'b0, dv_reg[QB-1][4].q})
                                                   : signed'({1'b0, dv_reg[QB-1][4].q});
            end

            // Cross product terms for x' = y' cross z'.
            cm_reg     <= cu_reg;
            pcr_reg[0] <= (2*UW)'(yp_reg[1]) * (2*UW)'(zp_reg[2]);
            pcr_reg[1] <= (2*UW)'(yp_reg[0]) * (2*UW)'(zp_reg[2]);
            pcr_reg[2] <= (2*UW)'(yp_reg[0]) * (2*UW)'(zp_reg[1]);
            pcr_reg[3] <= (2*UW)'(yp_reg[1]) * (2*UW)'(zp_reg[0]);
            zp_m_reg   <= zp_reg;
            yp_m_reg   <= yp_reg;

            // Round the cross product back to Q2.30.
            cr_reg    <= cm_reg;
            xp_reg[0] <= XPW'(frba_pkg::round_q30(frba_pkg::acc_t'(pcr_reg[0])));
            xp_reg[1] <= XPW'(frba_pkg::round_q30(-frba_pkg::acc_t'(pcr_reg[1])));
            xp_reg[2] <= XPW'(frba_pkg::round_q30(frba_pkg::acc_t'(pcr_reg[2])
                                                  - frba_pkg::acc_t'(pcr_reg[3])));
            zp_r_reg  <= zp_m_reg;
            yp_r_reg  <= yp_m_reg;

            // Projection products of the scattered vector on the three axes.
            pp_reg[0] <= PW'(cr_reg.vx) * PW'(xp_reg[0]);
            pp_reg[1] <= PW'(cr_reg.vy) * PW'(xp_reg[1]);
            pp_reg[2] <= PW'(cr_reg.vz) * PW'(xp_reg[2]);
            pp_reg[3] <= PW'(cr_reg.vx) * PW'(yp_r_reg[0]);
            pp_reg[4] <= PW'(cr_reg.vy) * PW'(yp_r_reg[1]);
            pp_reg[5] <= PW'(cr_reg.vx) * PW'(zp_r_reg[0]);
            pp_reg[6] <= PW'(cr_reg.vy) * PW'(zp_r_reg[1]);
            pp_reg[7] <= PW'(cr_reg.vz) * PW'(zp_r_reg[2]);

            // Dot product sums.
            acc_reg[0] <= SW'(pp_reg[0]) + SW'(pp_reg[1]) + SW'(pp_reg[2]);
            acc_reg[1] <= SW'(pp_reg[3]) + SW'(pp_reg[4]);
            acc_reg[2] <= SW'(pp_reg[5]) + SW'(pp_reg[6]) + SW'(pp_reg[7]);

            // Round to integers and saturate into the output range.
            rot_x_reg <= sat_out(frba_pkg::round_q30(frba_pkg::acc_t'(acc_reg[0])));
            rot_y_reg <= sat_out(frba_pkg::round_q30(frba_pkg::acc_t'(acc_reg[1])));
            rot_z_reg <= sat_out(frba_pkg::round_q30(frba_pkg::acc_t'(acc_reg[2])));
        end
    end

    // Reset empties the whole pipeline.
    a_reset_empty : assert property (@(posedge aclk) !aresetn |=> vld_reg == '0)
        else $error("pipeline not empty after reset");

    // A stall freezes the position of every item in flight.
    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("item moved or dropped during a stall");

    // The z' x and both y' unit components never exceed one in magnitude.
    a_unit_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[IU] |-> (zp_reg[0] <= UNIT_ONE && zp_reg[0] >= -UNIT_ONE
                         && yp_reg[0] <= UNIT_ONE && yp_reg[0] >= -UNIT_ONE
                         && yp_reg[1] <= UNIT_ONE && yp_reg[1] >= -UNIT_ONE))
        else $error("unit component out of range");

endmodule

[tb/tb.sv]
// Self-checking testbench for frame_rotation_to_beam_axes_top: a clocked driver
// and monitor, with the expected projections computed from each accepted transfer.
// Depends on the RTL top module only.
module tb;

    localparam int W          = 24;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 120;

    typedef struct {
        logic signed [W-1:0] ix, iy, iz, sx, sy, sz;
    } event_t;

    typedef struct {
        logic signed [W:0] x, y, z;
    } proj_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic signed [W-1:0] s_inc_x = '0, s_inc_y = '0, s_inc_z = '0;
    logic signed [W-1:0] s_sc_x = '0, s_sc_y = '0, s_sc_z = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [W:0] m_rot_x, m_rot_y, m_rot_z;

    event_t pending_events[$];
    proj_t  expected_proj[$];
    int     snd_idle_pct = 0;
    int     rcv_stall_pct = 0;
    bit     hold_request = 1'b0;
    bit     hold_taken = 1'b0;
    int     hold_left = 0;
    int     cycles = 0;
    int     errors = 0;
    int     sent = 0;
    int     checked = 0;

    frame_rotation_to_beam_axes_top #(.COMP_WIDTH(W)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_inc_x(s_inc_x), .s_inc_y(s_inc_y), .s_inc_z(s_inc_z),
        .s_sc_x(s_sc_x), .s_sc_y(s_sc_y), .s_sc_z(s_sc_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_rot_x(m_rot_x), .m_rot_y(m_rot_y), .m_rot_z(m_rot_z)
    );

    // Clock generation.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Cycle counter with a hard limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Integer square root, bit by bit.
    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Component divided by a Q.8 length, rounded and saturated to Q2.30.
    function automatic longint axis_unit(longint c, longint unsigned len);
        longint unsigned q;
        if (len == 0) return 0;
        q = ((magnitude(c) << 39) + len) / (2 * len);
        if (q > 64'd2147483647) q = 64'd2147483647;
        return c < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint drop_q30(longint v);
        longint unsigned m;
        m = (magnitude(v) + (64'd1 << 29)) >> 30;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [W:0] clamp_out(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< W) - 1;
        lo = -(64'sd1 <<< W);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[W:0];
    endfunction

    // Projection of the scattered vector onto the helicity frame of the incident one.
    function automatic proj_t project_event(event_t e);
        longint ux, uy, uz, vx, vy, vz;
        longint zx, zy, zz, yx, yy, xx, xy, xz;
        longint unsigned t2, s2, lz, ly;
        proj_t r;
        ux = e.ix; uy = e.iy; uz = e.iz;
        vx = e.sx; vy = e.sy; vz = e.sz;
        t2 = magnitude(ux) * magnitude(ux) + magnitude(uy) * magnitude(uy);
        s2 = t2 + magnitude(uz) * magnitude(uz);
        lz = root_floor(s2 << 16);
        ly = root_floor(t2 << 16);
        zx = axis_unit(ux, lz);
        zy = axis_unit(uy, lz);
        zz = axis_unit(uz, lz);
        yx = axis_unit(uy, ly);
        yy = axis_unit(-ux, ly);
        xx = drop_q30(yy * zz);
        xy = drop_q30(-(yx * zz));
        xz = drop_q30(yx * zy - yy * zx);
        r.x = clamp_out(drop_q30(vx * xx + vy * xy + vz * xz));
        r.y = clamp_out(drop_q30(vx * yx + vy * yy));
        r.z = clamp_out(drop_q30(vx * zx + vy * zy + vz * zz));
        return r;
    endfunction

    // Random component: mostly full range, with small values, zeros and extremes mixed in.
    function automatic logic signed [W-1:0] pick_comp();
        logic signed [W-1:0] c;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: c = W'($urandom);
            4: c = W'($urandom_range(0, 2000) - 1000);
            5: c = 0;
            6: c = $urandom_range(0, 1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            default: c = W'($urandom_range(0, 15) - 8);
        endcase
        return c;
    endfunction

    function automatic event_t random_event();
        event_t e;
        e.ix = pick_comp(); e.iy = pick_comp(); e.iz = pick_comp();
        e.sx = pick_comp(); e.sy = pick_comp(); e.sz = pick_comp();
        // Now and then put the incident vector on the lab z axis.
        if ($urandom_range(0, 9) == 0) begin
            e.ix = 0;
            e.iy = 0;
        end
        return e;
    endfunction

    function automatic event_t make_event(int ix, int iy, int iz, int sx, int sy, int sz);
        event_t e;
        e.ix = W'(ix); e.iy = W'(iy); e.iz = W'(iz);
        e.sx = W'(sx); e.sy = W'(sy); e.sz = W'(sz);
        return e;
    endfunction

    // Driver: offers the next pending event once the previous transfer has completed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                event_t e;
                e = pending_events.pop_front();
                s_inc_x <= e.ix; s_inc_y <= e.iy; s_inc_z <= e.iz;
                s_sc_x <= e.sx; s_sc_y <= e.sy; s_sc_z <= e.sz;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, including one long hold-off counted here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(0, 99) >= rcv_stall_pct;
        end
    end

    // Monitor: predicts on each input transfer and checks each result transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_proj.size() == 0) begin
                    $error("result transfer with no expected projection pending");
                    errors++;
                end else begin
                    proj_t p;
                    p = expected_proj.pop_front();
                    checked++;
                    if (m_rot_x !== p.x) begin
                        $error("rot_x expected %0d actual %0d", p.x, m_rot_x);
                        errors++;
                    end
                    if (m_rot_y !== p.y) begin
                        $error("rot_y expected %0d actual %0d", p.y, m_rot_y);
                        errors++;
                    end
                    if (m_rot_z !== p.z) begin
                        $error("rot_z expected %0d actual %0d", p.z, m_rot_z);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                event_t e;
                e.ix = s_inc_x; e.iy = s_inc_y; e.iz = s_inc_z;
                e.sx = s_sc_x; e.sy = s_sc_y; e.sz = s_sc_z;
                expected_proj.push_back(project_event(e));
                sent++;
            end
        end
    end

    task automatic drain_all();
        while (pending_events.size() != 0 || s_valid || expected_proj.size() != 0)
            @(negedge aclk);
    endtask

    // Stimulus sequence: directed cases, then random phases with varied idling.
    initial begin
        int mx;
        int mn;
        mx = (1 << (W - 1)) - 1;
        mn = -(1 << (W - 1));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: zero incident, lab z axis, extremes and small vectors.
        pending_events.push_back(make_event(0, 0, 0, 100, -200, 300));
        pending_events.push_back(make_event(0, 0, 5, 7, -9, 11));
        pending_events.push_back(make_event(0, 0, mn, mx, mn, mx));
        pending_events.push_back(make_event(0, 0, mx, mn, mn, mn));
        pending_events.push_back(make_event(mx, mx, mx, mx, mx, mx));
        pending_events.push_back(make_event(mn, mn, mn, mn, mn, mn));
        pending_events.push_back(make_event(mn, mn, mn, mx, mx, mx));
        pending_events.push_back(make_event(mx, 0, 0, mx, mn, mx));
        pending_events.push_back(make_event(0, mn, 0, mn, mx, mn));
        pending_events.push_back(make_event(mn, 0, 0, mn, mn, mn));
        pending_events.push_back(make_event(1, 0, 0, 1, 1, 1));
        pending_events.push_back(make_event(0, 1, 0, -1, -1, -1));
        pending_events.push_back(make_event(1, 1, 1, 1, 0, 0));
        pending_events.push_back(make_event(-1, 1, -1, mx, mx, mn));
        pending_events.push_back(make_event(3, 4, 0, 3, 4, 0));
        pending_events.push_back(make_event(3, 4, 12, 5, -5, 5));
        pending_events.push_back(make_event(mx, mn, 1, mn, mx, 1));
        pending_events.push_back(make_event(1, 1, mx, mn, mx, mn));
        pending_events.push_back(make_event(0, 0, 0, 0, 0, 0));
        pending_events.push_back(make_event(-1, -1, -1, -1, -1, -1));
        drain_all();

        // Phase without idling; the receiver holds off long enough to back up the pipe.
        for (int i = 0; i < 258; i++) pending_events.push_back(random_event());
        repeat (20) @(negedge aclk);
        hold_request = 1'b1;
        drain_all();

        // Sender idle about half the time.
        snd_idle_pct = 51;
        for (int i = 0; i < 258; i++) pending_events.push_back(random_event());
        drain_all();

        // Receiver stalling about half the time.
        snd_idle_pct = 0;
        rcv_stall_pct = 51;
        for (int i = 0; i < 258; i++) pending_events.push_back(random_event());
        drain_all();

        // Both sides idling lightly.
        snd_idle_pct = 10;
        rcv_stall_pct = 10;
        for (int i = 0; i < 258; i++) pending_events.push_back(random_event());
        drain_all();

        repeat (DRAIN_WAIT) @(negedge aclk);
        $display("Checked %0d projections from %0d events, including zero and on-axis",
                 checked, sent);
        $display("incident vectors, extremes, back-pressure and sender gaps.");
        if (errors == 0 && expected_proj.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
